>>> rtl/fsd_pkg.sv
// Shared types, constants and arithmetic helpers of the error-diffusion dither.
package fsd_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 13;
  localparam int ERR_W     = 18;
  localparam int MEM_W     = 3 * ERR_W;

  localparam logic signed [24:0] ERR_MAX = 25'sd131071;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEVEL  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Back end sequencer steps, also used by the channel lanes.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SUM  = 4'd1;
  localparam logic [3:0] ST_MUL  = 4'd2;
  localparam logic [3:0] ST_QNT  = 4'd3;
  localparam logic [3:0] ST_CLP  = 4'd4;
  localparam logic [3:0] ST_OLO  = 4'd5;
  localparam logic [3:0] ST_OHI  = 4'd6;
  localparam logic [3:0] ST_RLO  = 4'd7;
  localparam logic [3:0] ST_RHI  = 4'd8;
  localparam logic [3:0] ST_ERR  = 4'd9;
  localparam logic [3:0] ST_WR   = 4'd10;
  localparam logic [3:0] ST_WR2  = 4'd11;
  localparam logic [3:0] ST_DONE = 4'd12;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;
  } out_word_t;

  typedef struct packed {
    in_word_t         pix;
    logic [COL_W-1:0] col;
    logic             first_col;
    logic             first_row;
    logic             last_col;
    logic             last_row;
  } tag_t;

  typedef struct packed {
    logic [3:0]  step;
    logic        first_col;
    logic        first_row;
    logic        last_col;
    logic        last_row;
    logic [7:0]  lm1;
    logic [16:0] m_lo;
    logic [16:0] m_hi;
  } lane_ctl_t;

  // ceil(2^33 / (2^bits - 1)): reciprocal of twice the top level, scaled by 2^34.
  function automatic logic [33:0] recip(input logic [3:0] bits);
    logic [33:0] m;
    case (bits)
      4'd1:    m = 34'd8589934592;
      4'd2:    m = 34'd2863311531;
      4'd3:    m = 34'd1227133514;
      4'd4:    m = 34'd572662307;
      4'd5:    m = 34'd277094665;
      4'd6:    m = 34'd136348169;
      4'd7:    m = 34'd67637281;
      default: m = 34'd33686019;
    endcase
    return m;
  endfunction

  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [24:0] x);
    logic signed [24:0] y;
    if (x > ERR_MAX) begin
      y = ERR_MAX;
    end else if (x < -ERR_MAX) begin
      y = -ERR_MAX;
    end else begin
      y = x;
    end
    return y[ERR_W-1:0];
  endfunction

  // floor((e*k + 8) / 16), saturated.
  function automatic logic signed [ERR_W-1:0] share_err(input logic signed [20:0] e,
                                                      input logic [2:0] k);
    logic signed [24:0] p;
    logic signed [24:0] r;
    p = $signed({{4{e[20]}}, e}) * $signed({22'd0, k});
    r = (p + 25'sd8) >>> 4;
    return sat_err(r);
  endfunction

endpackage

>>> rtl/fsd_queue.sv
// Two-entry queue that decouples the pixel front end from the back end.
module fsd_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  fsd_pkg::tag_t push_data,
  input  logic         pop,
  output logic         full,
  output logic         not_empty,
  output fsd_pkg::tag_t head
);

  fsd_pkg::tag_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/fsd_front.sv
// Front end: accepts pixel words and tags each with its place in the frame.
module fsd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fsd_pkg::in_word_t in_data,
  input  logic [11:0]      image_width,
  input  logic [12:0]      image_height,
  input  logic             restart,
  input  logic             q_full,
  output logic             q_push,
  output fsd_pkg::tag_t    q_data
);

  logic [fsd_pkg::COL_W-1:0] col_r, col_nxt;
  logic [fsd_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [11:0] w_eff;
  logic [12:0] h_eff;
  logic        last_col;
  logic        last_row;

  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = 12'd1;
    end else if (image_width > 12'(fsd_pkg::MAX_WIDTH)) begin
      w_eff = 12'(fsd_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff    = (image_height == 13'd0) ? 13'd1 : image_height;
    last_col = (({1'b0, col_r} + 12'd1) >= w_eff);
    last_row = ((row_r + 13'd1) >= h_eff);
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.pix       = in_data;
    q_data.col       = col_r;
    q_data.first_col = (col_r == '0);
    q_data.first_row = (row_r == '0);
    q_data.last_col  = last_col;
    q_data.last_row  = last_row;
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (q_push) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + 13'd1;
      end else begin
        col_nxt = col_r + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> rtl/fsd_lane.sv
// One colour channel: error sum, quantizer, reconstruction and error shares.
module fsd_lane (
  input  logic                              clk,
  input  fsd_pkg::lane_ctl_t                ctl,
  input  logic [7:0]                        pix,
  input  logic signed [fsd_pkg::ERR_W-1:0]  above,
  output logic [7:0]                        out_val,
  output logic signed [fsd_pkg::ERR_W-1:0]  wprev,
  output logic signed [fsd_pkg::ERR_W-1:0]  pend
);

  logic signed [19:0] v_r;
  logic signed [28:0] n_r;
  logic [31:0]        qp_r;
  logic               neg_r;
  logic               big_r;
  logic [7:0]         q_r;
  logic [24:0]        num_r;
  logic [58:0]        acc_r;
  logic [7:0]         out_r;
  logic [16:0]        recon_r;
  logic signed [fsd_pkg::ERR_W-1:0] carry_r;
  logic signed [fsd_pkg::ERR_W-1:0] diag_r;
  logic signed [fsd_pkg::ERR_W-1:0] pend_r;
  logic signed [fsd_pkg::ERR_W-1:0] wprev_r;

  logic signed [19:0] above_v;
  logic signed [19:0] right_v;
  logic signed [19:0] v_sum;
  logic signed [28:0] n_val;
  logic [8:0]         q_raw;
  logic [7:0]         q_val;
  logic [41:0]        lo_prod;
  logic [41:0]        hi_prod;
  logic [58:0]        quo_sum;
  logic signed [20:0] err;
  logic signed [fsd_pkg::ERR_W-1:0] s7, s5, s3, s1, diag_v;

  always_comb begin
    above_v = ctl.first_row ? 20'sd0 : 20'(above);
    right_v = ctl.first_col ? 20'sd0 : 20'(carry_r);
    v_sum   = $signed({4'd0, pix, 8'd0}) + above_v + right_v;
    n_val   = v_r * $signed({1'b0, ctl.lm1}) + 29'sd32640;
    q_raw   = qp_r[31:23];
    if (neg_r) begin
      q_val = 8'd0;
    end else if (big_r || (q_raw > {1'b0, ctl.lm1})) begin
      q_val = ctl.lm1;
    end else begin
      q_val = q_raw[7:0];
    end
    lo_prod = num_r * ctl.m_lo;
    hi_prod = num_r * ctl.m_hi;
    quo_sum = acc_r + {hi_prod, 17'd0};
    err     = $signed({v_r[19], v_r}) - $signed({4'd0, recon_r});
    s7      = fsd_pkg::share_err(err, 3'd7);
    s5      = fsd_pkg::share_err(err, 3'd5);
    s3      = fsd_pkg::share_err(err, 3'd3);
    s1      = fsd_pkg::share_err(err, 3'd1);
    diag_v  = ctl.first_col ? '0 : diag_r;
  end

  always_ff @(posedge clk) begin
    case (ctl.step)
      fsd_pkg::ST_SUM: begin
        v_r <= v_sum;
      end
      fsd_pkg::ST_MUL: begin
        n_r <= n_val;
      end
      fsd_pkg::ST_QNT: begin
        qp_r  <= n_r[23:8] * 16'h8081;
        neg_r <= n_r[28];
        big_r <= |n_r[27:24];
      end
      fsd_pkg::ST_CLP: begin
        q_r   <= q_val;
        num_r <= 25'(q_val) * 25'd510 + 25'(ctl.lm1);
      end
      fsd_pkg::ST_OLO, fsd_pkg::ST_RLO: begin
        acc_r <= {17'd0, lo_prod};
      end
      fsd_pkg::ST_OHI: begin
        out_r <= quo_sum[41:34];
        num_r <= 25'(q_r) * 25'd130560 + 25'(ctl.lm1);
      end
      fsd_pkg::ST_RHI: begin
        recon_r <= quo_sum[50:34];
      end
      fsd_pkg::ST_ERR: begin
        carry_r <= ctl.last_col ? '0 : s7;
        diag_r  <= (ctl.last_col || ctl.last_row) ? '0 : s1;
        pend_r  <= ctl.last_row ? '0 :
                   fsd_pkg::sat_err(25'(s5) + 25'(diag_v));
        wprev_r <= ctl.last_row ? '0 :
                   fsd_pkg::sat_err(25'(pend_r) + 25'(s3));
      end
      default: begin
      end
    endcase
  end

  assign out_val = out_r;
  assign wprev   = wprev_r;
  assign pend    = pend_r;

endmodule

>>> rtl/fsd_back.sv
// Back end: step sequencer, next-row error memory, three lanes and result register.
module fsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [3:0]        level_bits,
  input  logic              q_valid,
  input  fsd_pkg::tag_t     q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fsd_pkg::out_word_t out_data
);

  logic [3:0]          state_r, state_nxt;
  fsd_pkg::tag_t       cur_r;
  logic                out_valid_r, out_valid_nxt;
  fsd_pkg::out_word_t  out_word_r;
  logic [fsd_pkg::MEM_W-1:0] mem [fsd_pkg::MAX_WIDTH];
  logic [fsd_pkg::MEM_W-1:0] rd_data_r;

  logic [3:0]          bits_eff;
  logic [33:0]         m_val;
  fsd_pkg::lane_ctl_t  ctl;
  logic [7:0]          r_out, g_out, b_out;
  logic signed [fsd_pkg::ERR_W-1:0] r_wp, g_wp, b_wp, r_pd, g_pd, b_pd;
  logic                load_out;
  logic                mem_we;
  logic [fsd_pkg::COL_W-1:0] mem_wa;
  logic [fsd_pkg::MEM_W-1:0] mem_wd;

  always_comb begin
    if (level_bits == 4'd0) begin
      bits_eff = 4'd1;
    end else if (level_bits > 4'd8) begin
      bits_eff = 4'd8;
    end else begin
      bits_eff = level_bits;
    end
    m_val         = fsd_pkg::recip(bits_eff);
    ctl.step      = state_r;
    ctl.first_col = cur_r.first_col;
    ctl.first_row = cur_r.first_row;
    ctl.last_col  = cur_r.last_col;
    ctl.last_row  = cur_r.last_row;
    ctl.lm1       = 8'((9'd1 << bits_eff) - 9'd1);
    ctl.m_lo      = m_val[16:0];
    ctl.m_hi      = m_val[33:17];
  end

  assign q_pop    = (state_r == fsd_pkg::ST_IDLE) && q_valid;
  assign load_out = (state_r == fsd_pkg::ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    case (state_r)
      fsd_pkg::ST_IDLE: state_nxt = q_valid ? fsd_pkg::ST_SUM : fsd_pkg::ST_IDLE;
      fsd_pkg::ST_SUM:  state_nxt = fsd_pkg::ST_MUL;
      fsd_pkg::ST_MUL:  state_nxt = fsd_pkg::ST_QNT;
      fsd_pkg::ST_QNT:  state_nxt = fsd_pkg::ST_CLP;
      fsd_pkg::ST_CLP:  state_nxt = fsd_pkg::ST_OLO;
      fsd_pkg::ST_OLO:  state_nxt = fsd_pkg::ST_OHI;
      fsd_pkg::ST_OHI:  state_nxt = fsd_pkg::ST_RLO;
      fsd_pkg::ST_RLO:  state_nxt = fsd_pkg::ST_RHI;
      fsd_pkg::ST_RHI:  state_nxt = fsd_pkg::ST_ERR;
      fsd_pkg::ST_ERR:  state_nxt = fsd_pkg::ST_WR;
      fsd_pkg::ST_WR:   state_nxt = cur_r.last_col ? fsd_pkg::ST_WR2 : fsd_pkg::ST_DONE;
      fsd_pkg::ST_WR2:  state_nxt = fsd_pkg::ST_DONE;
      fsd_pkg::ST_DONE: state_nxt = load_out ? fsd_pkg::ST_IDLE : fsd_pkg::ST_DONE;
      default:          state_nxt = fsd_pkg::ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fsd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (load_out) begin
      out_word_r.red_out   <= r_out;
      out_word_r.green_out <= g_out;
      out_word_r.blue_out  <= b_out;
      out_word_r.alpha_out <= cur_r.pix.alpha_in;
      out_word_r.frame_end <= cur_r.last_col && cur_r.last_row;
    end
  end

  // The entry left of the pixel is finished once its down-left share is known;
  // the last pixel of a row also stores its own entry.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = cur_r.col;
    mem_wd = {r_pd, g_pd, b_pd};
    if ((state_r == fsd_pkg::ST_WR) && !cur_r.first_col) begin
      mem_we = 1'b1;
      mem_wa = cur_r.col - 11'd1;
      mem_wd = {r_wp, g_wp, b_wp};
    end else if (state_r == fsd_pkg::ST_WR2) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (q_pop) begin
      rd_data_r <= mem[q_head.col];
    end
  end

  fsd_lane u_lane_r (
    .clk     (clk),
    .ctl     (ctl),
    .pix     (cur_r.pix.red_in),
    .above   (rd_data_r[53:36]),
    .out_val (r_out),
    .wprev   (r_wp),
    .pend    (r_pd)
  );

  fsd_lane u_lane_g (
    .clk     (clk),
    .ctl     (ctl),
    .pix     (cur_r.pix.green_in),
    .above   (rd_data_r[35:18]),
    .out_val (g_out),
    .wprev   (g_wp),
    .pend    (g_pd)
  );

  fsd_lane u_lane_b (
    .clk     (clk),
    .ctl     (ctl),
    .pix     (cur_r.pix.blue_in),
    .above   (rd_data_r[17:0]),
    .out_val (b_out),
    .wprev   (b_wp),
    .pend    (b_pd)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

>>> rtl/floyd_steinberg_dither_core.sv
// Top level of the Floyd-Steinberg error-diffusion dither core.
//
// Pixels arrive as RGBA words in raster order on the in_ channel and leave as
// dithered RGBA words on the out_ channel, one result word per input word.
// Both channels move a word at a clock edge where valid is high and stall is
// low. The cfg_ port is an APB-style register port: level bits at byte
// address 0, image width at 4 and image height at 8. Writing width or height
// restarts the frame at its first pixel. Registers are to be written only while
// the core is idle; the user must keep to this, the core does not enforce it.
// The back end works on one pixel at a time: its sequencer steps all three
// colour lanes through sum, multiply, quantize, two reciprocal divisions, each
// a low and a high partial product, and the error update, then writes the
// single-port next-row error memory, with an extra write step on the last
// pixel of a row.
// A two-word queue sits between the front end and the back end, and the result
// sits in an output register, so the input side keeps taking words while the
// receiver stalls, until the queue fills. Reset returns the registers to
// level 1, width 640 and height 480 and starts at the first pixel of a frame;
// the error memory needs no clearing because the first row ignores its reads.
module floyd_steinberg_dither_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fsd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output fsd_pkg::out_word_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [3:0]  level_bits_r, level_bits_nxt;
  logic [11:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        restart;

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_not_empty;
  fsd_pkg::tag_t q_data;
  fsd_pkg::tag_t q_head;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Register writes; a geometry write sends the front end back to the frame start.
  always_comb begin
    level_bits_nxt = level_bits_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    restart        = 1'b0;
    if (cfg_wr) begin
      case (cfg_idx)
        fsd_pkg::REG_LEVEL: begin
          level_bits_nxt = cfg_pwdata[3:0];
        end
        fsd_pkg::REG_WIDTH: begin
          width_nxt = cfg_pwdata[11:0];
          restart   = 1'b1;
        end
        fsd_pkg::REG_HEIGHT: begin
          height_nxt = cfg_pwdata[12:0];
          restart    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      fsd_pkg::REG_LEVEL:  cfg_prdata = {28'd0, level_bits_r};
      fsd_pkg::REG_WIDTH:  cfg_prdata = {20'd0, width_r};
      fsd_pkg::REG_HEIGHT: cfg_prdata = {19'd0, height_r};
      default:             cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_bits_r <= 4'd1;
      width_r      <= 12'd640;
      height_r     <= 13'd480;
    end else begin
      level_bits_r <= level_bits_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
    end
  end

  fsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .image_width  (width_r),
    .image_height (height_r),
    .restart      (restart),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_data)
  );

  fsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  fsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .level_bits (level_bits_r),
    .q_valid    (q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

>>> tb/tb_floyd_steinberg_dither_core.sv
// Testbench of the error-diffusion dither core: predicts each dithered word and checks it.

// Holds the dither state seen from outside and the queue of predicted words.
class dither_scoreboard;
  localparam longint ERR_LIM = (64'sd1 <<< 17) - 1;

  int unsigned        level_bits;
  int unsigned        image_width;
  int unsigned        image_height;
  int                 err_below[3][fsd_pkg::MAX_WIDTH];
  int                 err_right[3];
  int                 err_diag[3];
  int unsigned        col;
  int unsigned        row;
  fsd_pkg::out_word_t dithered_q[$];
  int                 mismatches;

  function new();
    level_bits   = 1;
    image_width  = 640;
    image_height = 480;
    foreach (err_below[c, x]) err_below[c][x] = 0;
    restart();
    mismatches = 0;
  endfunction

  function void restart();
    col = 0;
    row = 0;
    for (int c = 0; c < 3; c++) begin
      err_right[c] = 0;
      err_diag[c]  = 0;
    end
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] value);
    if (idx == fsd_pkg::REG_LEVEL) begin
      level_bits = value[3:0];
    end else if (idx == fsd_pkg::REG_WIDTH) begin
      image_width = value[11:0];
      restart();
    end else if (idx == fsd_pkg::REG_HEIGHT) begin
      image_height = value[12:0];
      restart();
    end
  endfunction

  function longint fdiv(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  function int sat(longint v);
    if (v > ERR_LIM) return int'(ERR_LIM);
    if (v < -ERR_LIM) return int'(-ERR_LIM);
    return int'(v);
  endfunction

  function int portion(longint e, longint k);
    return sat(fdiv(e * k + 8, 16));
  endfunction

  function int pending();
    return dithered_q.size();
  endfunction

  // Works out the dithered word for one accepted pixel and advances the state.
  function void note_pixel(fsd_pkg::in_word_t p);
    int unsigned        bits, w, h, x, y;
    longint             lm1, scale, v, q, recon, e;
    bit                 last_col, last_row;
    logic [7:0]         pix[3];
    logic [7:0]         res[3];
    fsd_pkg::out_word_t o;
    bits = level_bits;
    w = image_width;
    h = image_height;
    if (bits < 1) bits = 1;
    if (bits > 8) bits = 8;
    if (w < 1) w = 1;
    if (w > fsd_pkg::MAX_WIDTH) w = fsd_pkg::MAX_WIDTH;
    if (h < 1) h = 1;
    if (col >= w) col = w - 1;
    if (row >= h) row = h - 1;
    x = col;
    y = row;
    last_col = (x + 1 >= w);
    last_row = (y + 1 >= h);
    lm1 = (64'sd1 <<< bits) - 1;
    scale = 255 * 256;
    if (x == 0 && y == 0) foreach (err_below[c, i]) err_below[c][i] = 0;
    if (x == 0) begin
      for (int c = 0; c < 3; c++) begin
        err_right[c] = 0;
        err_diag[c]  = 0;
      end
    end
    pix[0] = p.red_in;
    pix[1] = p.green_in;
    pix[2] = p.blue_in;
    for (int c = 0; c < 3; c++) begin
      v = (longint'(pix[c]) <<< 8) + err_below[c][x] + err_right[c];
      q = fdiv(2 * v * lm1 + scale, 2 * scale);
      if (q < 0) q = 0;
      if (q > lm1) q = lm1;
      res[c] = 8'(fdiv(2 * q * 255 + lm1, 2 * lm1));
      recon = fdiv(2 * q * scale + lm1, 2 * lm1);
      e = v - recon;
      err_right[c] = last_col ? 0 : portion(e, 7);
      if (last_row) begin
        err_below[c][x] = 0;
        err_diag[c] = 0;
      end else begin
        if (x > 0) err_below[c][x-1] = sat(longint'(err_below[c][x-1]) + portion(e, 3));
        err_below[c][x] = sat(longint'(portion(e, 5)) + err_diag[c]);
        err_diag[c] = last_col ? 0 : portion(e, 1);
      end
    end
    o.red_out   = res[0];
    o.green_out = res[1];
    o.blue_out  = res[2];
    o.alpha_out = p.alpha_in;
    o.frame_end = last_col && last_row;
    dithered_q.push_back(o);
    if (last_col) begin
      col = 0;
      row = last_row ? 0 : y + 1;
    end else begin
      col = x + 1;
    end
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  task check_result(fsd_pkg::out_word_t r);
    fsd_pkg::out_word_t want;
    if (dithered_q.size() == 0) begin
      report_mismatch("word with nothing expected, red", r.red_out, -1);
      return;
    end
    want = dithered_q.pop_front();
    if (r.red_out !== want.red_out) report_mismatch("red", r.red_out, want.red_out);
    if (r.green_out !== want.green_out) report_mismatch("green", r.green_out, want.green_out);
    if (r.blue_out !== want.blue_out) report_mismatch("blue", r.blue_out, want.blue_out);
    if (r.alpha_out !== want.alpha_out) report_mismatch("alpha", r.alpha_out, want.alpha_out);
    if (r.frame_end !== want.frame_end) report_mismatch("frame_end", r.frame_end, want.frame_end);
  endtask
endclass

module tb_floyd_steinberg_dither_core;
  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  fsd_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_stall;
  fsd_pkg::out_word_t out_data;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [3:0]         cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  dither_scoreboard sb;

  // Idling percentages for the two sides; hold_req asks the stall process for a long hold.
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  bit          hold_req;

  floyd_steinberg_dither_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, or for a long counted stretch when asked to.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Every word taken from the result channel is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // An APB write: setup cycle, then access cycle; the register takes the value at the
  // edge that closes the access cycle, which is when the prediction is updated too.
  task write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Waits until every predicted word has come back, then lets the pipeline drain.
  task drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offers one pixel and waits for the edge that accepts it. Valid is left high, unless a
  // random idle gap is drawn, so a following word can be offered back to back.
  task send_pixel(fsd_pkg::in_word_t p);
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  function logic [7:0] rand_level8();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function fsd_pkg::in_word_t rand_pixel();
    fsd_pkg::in_word_t p;
    p.red_in   = rand_level8();
    p.green_in = rand_level8();
    p.blue_in  = rand_level8();
    p.alpha_in = 8'($urandom_range(255));
    return p;
  endfunction

  task send_burst(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
    in_valid <= 1'b0;
  endtask

  task set_idling(int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 70; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 70; end
      default: begin idle_pct = 7; stall_pct = 7; end
    endcase
  endtask

  initial begin
    fsd_pkg::in_word_t p;
    sb = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_stall   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_req  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: a few pixels under reset geometry, then a four by three frame
    // whose red cycles through black, white and mid-grey, at one level bit.
    send_burst(3);
    drain();
    write_reg(fsd_pkg::REG_WIDTH, 4);
    write_reg(fsd_pkg::REG_HEIGHT, 3);
    for (int i = 0; i < 12; i++) begin
      p.red_in   = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hff : 8'h80;
      p.green_in = 8'hff - p.red_in;
      p.blue_in  = 8'h7f;
      p.alpha_in = (i % 2) ? 8'hff : 8'h00;
      send_pixel(p);
    end
    in_valid <= 1'b0;
    drain();
    // Level bits of zero and above eight are clamped; width and height of zero give
    // a one-pixel frame.
    write_reg(fsd_pkg::REG_LEVEL, 0);
    write_reg(fsd_pkg::REG_WIDTH, 0);
    write_reg(fsd_pkg::REG_HEIGHT, 0);
    send_burst(3);
    drain();
    write_reg(fsd_pkg::REG_LEVEL, 15);
    send_burst(3);
    drain();
    write_reg(fsd_pkg::REG_LEVEL, 9);
    write_reg(fsd_pkg::REG_WIDTH, 3);
    write_reg(fsd_pkg::REG_HEIGHT, 1);
    send_burst(4);
    drain();

    // Widest and tallest geometry, and a width past the row buffer that is clamped.
    write_reg(fsd_pkg::REG_LEVEL, 8);
    write_reg(fsd_pkg::REG_WIDTH, 2048);
    write_reg(fsd_pkg::REG_HEIGHT, 4096);
    send_burst(30);
    drain();
    write_reg(fsd_pkg::REG_WIDTH, 4095);
    write_reg(fsd_pkg::REG_HEIGHT, 8191);
    send_burst(30);
    drain();

    // Random phases with small frames so that rows and frames turn over often.
    for (int ph = 0; ph < 16; ph++) begin
      set_idling(ph % 4);
      if (ph % 3 == 0) write_reg(fsd_pkg::REG_LEVEL, $urandom_range(15));
      else write_reg(fsd_pkg::REG_LEVEL, (ph % 2) ? 1 : 8);
      write_reg(fsd_pkg::REG_WIDTH, $urandom_range(1, 9));
      write_reg(fsd_pkg::REG_HEIGHT, $urandom_range(1, 6));
      if (ph == 4) begin
        // Long receiver hold while words keep coming, so the core backs up.
        hold_req = 1'b1;
        send_burst(50);
        drain();
      end
      send_burst(50);
      // The sender stops until every word of the first half has come back.
      while (sb.pending() != 0) @(posedge clk);
      // A level change mid-frame keeps the position.
      if (ph % 5 == 2) begin
        repeat (20) @(posedge clk);
        write_reg(fsd_pkg::REG_LEVEL, $urandom_range(1, 8));
      end
      send_burst(50);
      drain();
    end

    set_idling(0);
    drain();
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end
endmodule

>>> files.f
rtl/fsd_pkg.sv
rtl/fsd_queue.sv
rtl/fsd_front.sv
rtl/fsd_lane.sv
rtl/fsd_back.sv
rtl/floyd_steinberg_dither_core.sv
tb/tb_floyd_steinberg_dither_core.sv
